### rtl/core/rgi_pkg.sv
// Shared types and constants for the range gap interpolator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package rgi_pkg;

  localparam int MAX_GAP_W = 4;
  localparam logic [MAX_GAP_W-1:0] MAX_GAP_RESET = 4'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic pend_inc;
    logic div_start;
    logic qr_load;
    logic emit_fill;
    logic emit_interp;
    logic emit_last;
  } rgi_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic prior_valid;
    logic cur_gap;
    logic cur_last;
    logic pend_zero;
    logic pend_one;
    logic over_lim;
    logic run_over;
    logic div_done;
    logic out_free;
  } rgi_status_t;

endpackage

`default_nettype wire

### rtl/core/range_gap_interpolator_core.sv
// Lidar range gap filler: one sample in, zero or more range positions out.
// A new sample is taken only in the idle state, once the last one is fully done; a held
// gap emits nothing, any other sample emits each flushed or filled gap position and then
// its own, and a filled run first waits for the serial divider that splits the range step.
// Output stalls hold the controller in place.
// Reset (rst_n, synchronous): no held gaps, no prior range, max_gap back to 2.
`timescale 1ns / 1ps
`default_nettype none

module range_gap_interpolator_core import rgi_pkg::*; #(
  parameter int RANGE_BITS = 16,
  parameter int GAP_LIMIT  = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [RANGE_BITS-1:0] in_range,
  input  wire logic                  in_gap,
  input  wire logic                  in_scan_last,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [RANGE_BITS-1:0]      out_range,
  output logic                       out_gap,
  output logic                       out_scan_end,
  output logic                       out_run_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [MAX_GAP_W-1:0]  cfg_max_gap
);

  rgi_cmd_t    cmd;
  rgi_status_t status;

  assign cfg_ready = 1'b1;

  rgi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rgi_datapath #(
    .RANGE_BITS (RANGE_BITS),
    .GAP_LIMIT  (GAP_LIMIT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_range     (in_range),
    .in_gap       (in_gap),
    .in_scan_last (in_scan_last),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_max_gap  (cfg_max_gap),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_range    (out_range),
    .out_gap      (out_gap),
    .out_scan_end (out_scan_end),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire

### rtl/core/rgi_div.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; used by rgi_datapath to split the range step over the gap run.
`timescale 1ns / 1ps
`default_nettype none

module rgi_div #(
  parameter int DW = 16,
  parameter int VW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot,
  output logic [VW-1:0]      rem
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quot_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [VW:0]      shifted;
  logic             fits;
  logic [VW:0]      diff;

  assign shifted = {rem_r, quot_r[DW-1]};
  assign fits    = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[DW-2:0], fits};
      rem_r  <= fits ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

### rtl/core/rgi_datapath.sv
// Datapath: sample state, config register, interpolation stepper and output register.
// Depends on rgi_pkg and rgi_div.
`timescale 1ns / 1ps
`default_nettype none

module rgi_datapath import rgi_pkg::*; #(
  parameter int RANGE_BITS = 16,
  parameter int GAP_LIMIT  = 15
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rgi_cmd_t              cmd,
  output rgi_status_t                status,
  input  wire logic [RANGE_BITS-1:0] in_range,
  input  wire logic                  in_gap,
  input  wire logic                  in_scan_last,
  input  wire logic                  cfg_we,
  input  wire logic [MAX_GAP_W-1:0]  cfg_max_gap,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [RANGE_BITS-1:0]      out_range,
  output logic                       out_gap,
  output logic                       out_scan_end,
  output logic                       out_run_last
);

  localparam int PEND_W = $clog2(GAP_LIMIT + 1);
  localparam int CW     = ((PEND_W > MAX_GAP_W) ? PEND_W : MAX_GAP_W) + 1;

  logic [MAX_GAP_W-1:0]  max_gap_r;
  logic [RANGE_BITS-1:0] prior_range_r;
  logic                  prior_valid_r;
  logic [PEND_W-1:0]     pending_r;
  logic [RANGE_BITS-1:0] cur_range_r;
  logic                  cur_gap_r;
  logic                  cur_last_r;
  logic                  neg_r;
  logic [CW-1:0]         divr_r;
  logic [RANGE_BITS-1:0] q_r;
  logic [CW-1:0]         rem_r;
  logic                  out_valid_r;
  logic [RANGE_BITS-1:0] out_range_r;
  logic                  out_gap_r;
  logic                  out_end_r;
  logic                  out_runl_r;

  logic [CW-1:0]         lim;
  logic [CW-1:0]         pend_ext;
  logic                  neg;
  logic [RANGE_BITS-1:0] mag;
  logic                  div_done;
  logic [RANGE_BITS-1:0] div_q;
  logic [CW-1:0]         div_rem;
  logic                  rem_ge;
  logic [CW:0]           rem_wrap;
  logic [RANGE_BITS-1:0] q_nxt;
  logic [CW-1:0]         rem_nxt;
  logic [RANGE_BITS-1:0] interp_val;
  logic                  out_free;
  logic                  emit;

  assign lim = (CW'(max_gap_r) < CW'(GAP_LIMIT)) ? CW'(max_gap_r) : CW'(GAP_LIMIT);
  assign pend_ext = CW'(pending_r);

  assign neg = (cur_range_r > prior_range_r);
  assign mag = neg ? (cur_range_r - prior_range_r) : (prior_range_r - cur_range_r);

  rgi_div #(
    .DW (RANGE_BITS),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (mag),
    .divisor  (pend_ext + 1'b1),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  // Step the partial quotient down by one run position: remove |d| from j*|d|.
  assign rem_ge   = (rem_r >= div_rem);
  assign rem_wrap = {1'b0, rem_r} + {1'b0, divr_r} - {1'b0, div_rem};
  assign q_nxt    = rem_ge ? (q_r - div_q) : (q_r - div_q - 1'b1);
  assign rem_nxt  = rem_ge ? (rem_r - div_rem) : rem_wrap[CW-1:0];
  assign interp_val = neg_r ? (cur_range_r - q_nxt) : (cur_range_r + q_nxt);

  assign out_free = !out_valid_r || out_ready;
  assign emit     = cmd.emit_fill || cmd.emit_interp || cmd.emit_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_gap_r     <= MAX_GAP_RESET;
      prior_valid_r <= 1'b0;
      pending_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_gap_r <= cfg_max_gap;
      end
      if (cmd.pend_inc) begin
        pending_r <= pending_r + 1'b1;
      end else if (cmd.emit_fill || cmd.emit_interp) begin
        pending_r <= pending_r - 1'b1;
      end else if (cmd.emit_last) begin
        pending_r <= '0;
      end
      if (cmd.emit_last) begin
        prior_valid_r <= !cur_gap_r && !cur_last_r;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_range_r <= in_range;
      cur_gap_r   <= in_gap;
      cur_last_r  <= in_scan_last;
    end
    if (cmd.emit_last && !cur_gap_r) begin
      prior_range_r <= cur_range_r;
    end
    if (cmd.div_start) begin
      neg_r  <= neg;
      divr_r <= pend_ext + 1'b1;
    end
    if (cmd.qr_load) begin
      q_r   <= mag;
      rem_r <= '0;
    end else if (cmd.emit_interp) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.emit_fill) begin
      out_range_r <= '0;
      out_gap_r   <= 1'b1;
      out_end_r   <= 1'b0;
      out_runl_r  <= 1'b0;
    end else if (cmd.emit_interp) begin
      out_range_r <= interp_val;
      out_gap_r   <= 1'b0;
      out_end_r   <= 1'b0;
      out_runl_r  <= 1'b0;
    end else if (cmd.emit_last) begin
      out_range_r <= cur_gap_r ? '0 : cur_range_r;
      out_gap_r   <= cur_gap_r;
      out_end_r   <= cur_last_r;
      out_runl_r  <= 1'b1;
    end
  end

  always_comb begin
    status.prior_valid = prior_valid_r;
    status.cur_gap     = cur_gap_r;
    status.cur_last    = cur_last_r;
    status.pend_zero   = (pending_r == '0);
    status.pend_one    = (pending_r == PEND_W'(1));
    status.over_lim    = ((pend_ext + 1'b1) > lim);
    status.run_over    = (pend_ext > lim);
    status.div_done    = div_done;
    status.out_free    = out_free;
  end

  assign out_valid    = out_valid_r;
  assign out_range    = out_range_r;
  assign out_gap      = out_gap_r;
  assign out_scan_end = out_end_r;
  assign out_run_last = out_runl_r;

endmodule

`default_nettype wire

### rtl/core/rgi_ctrl.sv
// Controller state machine: decides per sample whether to hold, pass through, flush or fill.
// Depends on rgi_pkg; drives rgi_datapath through command signals.
`timescale 1ns / 1ps
`default_nettype none

module rgi_ctrl import rgi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire rgi_status_t status,
  output rgi_cmd_t         cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_FLUSH    = 3'd2;
  localparam logic [2:0] S_DIV      = 3'd3;
  localparam logic [2:0] S_INTERP   = 3'd4;
  localparam logic [2:0] S_LAST     = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status.cur_gap) begin
          if (!status.prior_valid) begin
            state_nxt = S_LAST;
          end else if (status.over_lim || status.cur_last) begin
            state_nxt = status.pend_zero ? S_LAST : S_FLUSH;
          end else begin
            // hold the gap until the run closes
            cmd.pend_inc = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          if (status.pend_zero) begin
            state_nxt = S_LAST;
          end else if (status.run_over) begin
            state_nxt = S_FLUSH;
          end else begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end
      S_FLUSH: begin
        if (status.out_free) begin
          cmd.emit_fill = 1'b1;
          if (status.pend_one) begin
            state_nxt = S_LAST;
          end
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.qr_load = 1'b1;
          state_nxt   = S_INTERP;
        end
      end
      S_INTERP: begin
        if (status.out_free) begin
          cmd.emit_interp = 1'b1;
          if (status.pend_one) begin
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        if (status.out_free) begin
          cmd.emit_last = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

### dv/range_gap_interpolator_core_tb.sv
// Testbench for range_gap_interpolator_core: gap filling on a lidar range stream.
// Needs rgi_pkg and the core RTL; a scoreboard class predicts every emitted position.
`timescale 1ns / 1ps

module range_gap_interpolator_core_tb;
  import rgi_pkg::*;

  localparam int RB          = 16;
  localparam int GAP_CAP     = 15;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 40;

  typedef struct {
    logic [RB-1:0] range_val;
    logic          gap;
    logic          scan_end;
    logic          run_last;
  } range_pos_t;

  // Predicts the positions emitted per sample and checks them in order.
  class gap_fill_scoreboard;
    range_pos_t    expected_positions[$];
    int unsigned   max_gap;
    logic [RB-1:0] prior_range;
    bit            prior_valid;
    int unsigned   held_gaps;
    int            mismatches;
    int            n_samples;
    int            n_positions;
    int            n_filled;
    int            n_unfilled;

    function new();
      max_gap     = MAX_GAP_RESET;
      prior_range = '0;
      prior_valid = 1'b0;
      held_gaps   = 0;
      mismatches  = 0;
      n_samples   = 0;
      n_positions = 0;
      n_filled    = 0;
      n_unfilled  = 0;
    endfunction

    function void set_max_gap(logic [MAX_GAP_W-1:0] v);
      max_gap = v;
    endfunction

    function void push_position(logic [RB-1:0] r, logic g, logic e);
      range_pos_t p;
      p.range_val = r;
      p.gap       = g;
      p.scan_end  = e;
      p.run_last  = 1'b0;
      expected_positions.insert(expected_positions.size(), p);
      if (g) n_unfilled++;
    endfunction

    function void note_sample(logic [RB-1:0] r, logic g, logic last);
      int unsigned lim;
      int          n_before;
      longint      v0;
      longint      v1;
      longint      dv;
      longint      val;
      longint      j;
      lim      = (max_gap < GAP_CAP) ? max_gap : GAP_CAP;
      n_before = expected_positions.size();
      n_samples++;
      if (g) begin
        if (!prior_valid) begin
          push_position('0, 1'b1, last);
        end else if (held_gaps + 1 > lim || last) begin
          // flush the held run unfilled and drop the prior range
          repeat (held_gaps) push_position('0, 1'b1, 1'b0);
          push_position('0, 1'b1, last);
          held_gaps   = 0;
          prior_valid = 1'b0;
        end else begin
          held_gaps++;
        end
      end else begin
        if (held_gaps > 0) begin
          if (held_gaps <= lim) begin
            v1 = r;
            v0 = prior_range;
            dv = held_gaps + 1;
            for (j = held_gaps; j >= 1; j--) begin
              val = v1 + (j * (v0 - v1)) / dv;
              push_position(val[RB-1:0], 1'b0, 1'b0);
              n_filled++;
            end
          end else begin
            repeat (held_gaps) push_position('0, 1'b1, 1'b0);
          end
        end
        push_position(r, 1'b0, last);
        prior_range = r;
        prior_valid = 1'b1;
        held_gaps   = 0;
      end
      if (last) begin
        prior_valid = 1'b0;
        held_gaps   = 0;
      end
      if (expected_positions.size() > n_before)
        expected_positions[expected_positions.size()-1].run_last = 1'b1;
    endfunction

    function void check_position(logic [RB-1:0] r, logic g, logic e, logic l);
      range_pos_t exp_pos;
      if (expected_positions.size() == 0) begin
        $error("unexpected result: range_out %h gap_out %b", r, g);
        mismatches++;
        return;
      end
      exp_pos = expected_positions.pop_front();
      n_positions++;
      if (exp_pos.range_val !== r) begin
        $error("range_out: expected %h, actual %h", exp_pos.range_val, r);
        mismatches++;
      end
      if (exp_pos.gap !== g) begin
        $error("gap_out: expected %b, actual %b", exp_pos.gap, g);
        mismatches++;
      end
      if (exp_pos.scan_end !== e) begin
        $error("scan_end_out: expected %b, actual %b", exp_pos.scan_end, e);
        mismatches++;
      end
      if (exp_pos.run_last !== l) begin
        $error("run_last: expected %b, actual %b", exp_pos.run_last, l);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_ready;
  logic [RB-1:0]        in_range     = '0;
  logic                 in_gap       = 1'b0;
  logic                 in_scan_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready    = 1'b0;
  logic [RB-1:0]        out_range;
  logic                 out_gap;
  logic                 out_scan_end;
  logic                 out_run_last;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [MAX_GAP_W-1:0] cfg_max_gap  = '0;

  gap_fill_scoreboard sb = new();
  bit steady = 1'b0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  range_gap_interpolator_core #(
    .RANGE_BITS(RB),
    .GAP_LIMIT (GAP_CAP)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_range    (in_range),
    .in_gap      (in_gap),
    .in_scan_last(in_scan_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_range   (out_range),
    .out_gap     (out_gap),
    .out_scan_end(out_scan_end),
    .out_run_last(out_run_last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_max_gap (cfg_max_gap)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [RB-1:0] rand_range();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return RB'($urandom);
  endfunction

  // Called in the time step of a rising edge; returns at the accepting edge.
  task automatic send_sample(logic [RB-1:0] r, logic g, logic last);
    int unsigned idle;
    idle = steady ? 0 : $urandom_range(0, 8);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_range     <= r;
    in_gap       <= g;
    in_scan_last <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(r, g, last);
  endtask

  // Hold off the sender until every predicted position has come out.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (sb.expected_positions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_max_gap(logic [MAX_GAP_W-1:0] v);
    cfg_valid   <= 1'b1;
    cfg_max_gap <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_max_gap(v);
    cfg_writes++;
  endtask

  function automatic logic rand_last();
    return ($urandom_range(0, 15) == 0);
  endfunction

  task automatic random_phase(int n_items);
    int          sent;
    int unsigned kind;
    int unsigned run_len;
    int unsigned lim;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      lim  = (sb.max_gap == 0) ? 1 : sb.max_gap;
      if (kind < 6) begin
        // mostly fillable runs, some overlong; then the closing sample
        run_len = (kind < 5) ? $urandom_range(1, lim) : $urandom_range(lim + 1, lim + 3);
        repeat (run_len) send_sample(rand_range(), 1'b1, rand_last());
        send_sample(rand_range(), 1'b0, rand_last());
        sent += run_len + 1;
      end else if (kind < 9) begin
        send_sample(rand_range(), 1'b0, rand_last());
        sent++;
      end else begin
        send_sample(rand_range(), 1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end
    end
  endtask

  // Receiver: random stalls per position, ready held when the next stall is zero.
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_position(out_range, out_gap, out_scan_end, out_run_last);
    end
  end

  // Watchdog: abort when no transaction moves on any channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [MAX_GAP_W-1:0] phase_gap [6];
    int p;
    phase_gap[0] = 4'd15;
    phase_gap[1] = 4'd0;
    phase_gap[2] = 4'd1;
    phase_gap[3] = 4'd7;
    phase_gap[4] = 4'd3;
    phase_gap[5] = MAX_GAP_W'($urandom_range(0, 15));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, at the reset limit of two
    send_sample(rand_range(), 1'b1, 1'b0);          // leading gap
    send_sample(16'h1000, 1'b0, 1'b0);
    send_sample(rand_range(), 1'b1, 1'b0);
    send_sample(rand_range(), 1'b1, 1'b0);
    send_sample(16'h2000, 1'b0, 1'b0);              // two filled positions
    send_sample(16'hFFFF, 1'b0, 1'b0);
    send_sample(rand_range(), 1'b1, 1'b0);
    send_sample(16'h0000, 1'b0, 1'b0);              // falling step, full range
    send_sample(rand_range(), 1'b1, 1'b0);
    send_sample(16'hFFFF, 1'b0, 1'b0);              // rising step, full range
    repeat (4) send_sample(rand_range(), 1'b1, 1'b0); // overlong run, then pass-through
    send_sample(16'h0005, 1'b0, 1'b0);
    send_sample(rand_range(), 1'b1, 1'b0);
    send_sample(rand_range(), 1'b1, 1'b1);          // gap still open at scan end
    send_sample(16'h1234, 1'b0, 1'b1);              // scan boundary
    send_sample(rand_range(), 1'b1, 1'b0);          // leading gap of the new scan
    drain_block();
    write_max_gap(4'd4);
    send_sample(16'd100, 1'b0, 1'b0);
    repeat (3) send_sample(rand_range(), 1'b1, 1'b0);
    drain_block();
    write_max_gap(4'd1);                            // lower limit with three gaps held
    send_sample(16'd200, 1'b0, 1'b1);
    drain_block();

    for (p = 0; p < 6; p++) begin
      write_max_gap(phase_gap[p]);
      steady = (p == 3);
      random_phase(46);
      drain_block();
    end
    steady = 1'b0;

    $display("Covered %0d samples and %0d positions (%0d interpolated, %0d unfilled)",
             sb.n_samples, sb.n_positions, sb.n_filled, sb.n_unfilled);
    $display("across %0d max_gap settings, including both extremes", cfg_writes);
    if (sb.mismatches == 0 && sb.expected_positions.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
